// ===== hw/rtl/sepx_pkg.sv =====
// shared constants, codes and types of the smoothed equal-power crossfader
// depends on nothing; every other rtl file of the block depends on it

package sepx_pkg;

    // default values of the top level parameters
    localparam int SINE_TABLE_SIZE_DEF = 1024;
    localparam int SAMPLE_BITS_DEF     = 24;

    // comparison store depth, bound to the 16-bit load index and playhead
    localparam int STORE_DEPTH = 65536;

    // fixed field widths
    localparam int MIX_BITS       = 17;
    localparam int LEN_BITS       = 17;
    localparam int PH_BITS        = 16;
    localparam int INDEX_BITS     = 16;
    localparam int HOST_BITS      = 48;
    localparam int CH_BITS        = 2;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 17;

    // fixed point constants
    localparam logic [MIX_BITS-1:0] MIX_ONE      = 17'd65536;
    localparam logic [11:0]         SMOOTH_Q16   = 12'd3277;
    localparam logic [63:0]         HALF_PI_Q30  = 64'd1686629713;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_TARGET_MIX    = 2'd0,
        REG_CHANNEL_COUNT = 2'd1,
        REG_LEFT_LENGTH   = 2'd2,
        REG_RIGHT_LENGTH  = 2'd3
    } cfg_reg_t;

    // request modes
    typedef enum logic {
        MODE_LOAD    = 1'b0,
        MODE_PROCESS = 1'b1
    } mode_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_FETCH,
        ST_PROD,
        ST_SUM,
        ST_WRAP
    } state_t;

    // modulo unit handshake
    typedef struct packed {
        logic                 start;
        logic [HOST_BITS-1:0] dividend;
        logic [LEN_BITS-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [LEN_BITS-1:0] remainder;
    } div_resp_t;

    // per lane strobes
    typedef struct packed {
        logic rd_en;
        logic snap_ok;
        logic prod_en;
    } lane_ctrl_t;

endpackage

// ===== hw/rtl/sepx_in_if.sv =====
// input channel of the crossfader: valid/ready plus one frame or load request
// depends on sepx_pkg

interface sepx_in_if #(
    parameter int SAMPLE_BITS = sepx_pkg::SAMPLE_BITS_DEF
);
    import sepx_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic [INDEX_BITS-1:0]         load_index;
    logic                          block_start;
    logic                          is_playing;
    logic [HOST_BITS-1:0]          host_position;

    modport source (
        output valid, mode, left_sample, right_sample, load_index,
               block_start, is_playing, host_position,
        input  ready
    );

    modport sink (
        input  valid, mode, left_sample, right_sample, load_index,
               block_start, is_playing, host_position,
        output ready
    );

endinterface

// ===== hw/rtl/sepx_out_if.sv =====
// output channel of the crossfader: valid/ready plus one mixed stereo frame
// depends on sepx_pkg

interface sepx_out_if #(
    parameter int SAMPLE_BITS = sepx_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;

    modport source (
        output valid, out_left, out_right,
        input  ready
    );

    modport sink (
        input  valid, out_left, out_right,
        output ready
    );

endinterface

// ===== hw/rtl/sepx_gain_rom.sv =====
// quarter-wave sine gain rom with two registered read ports (sin and cos)
// contents built at elaboration from a q2.30 taylor series; depends on sepx_pkg

module sepx_gain_rom #(
    parameter int SINE_TABLE_SIZE = sepx_pkg::SINE_TABLE_SIZE_DEF,
    parameter int IW              = $clog2(SINE_TABLE_SIZE + 1)
) (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [IW-1:0]                 sin_idx,
    input  logic [IW-1:0]                 cos_idx,
    output logic [sepx_pkg::MIX_BITS-1:0] sin_gain,
    output logic [sepx_pkg::MIX_BITS-1:0] cos_gain
);
    import sepx_pkg::*;

    logic [MIX_BITS-1:0] rom_q [SINE_TABLE_SIZE+1];
    logic [MIX_BITS-1:0] sin_gain_reg;
    logic [MIX_BITS-1:0] cos_gain_reg;

    // one entry per angle step: sin(pi/2 * i / size) rounded to q1.16
    for (genvar g = 0; g <= SINE_TABLE_SIZE; g++) begin : g_entry
        localparam logic [63:0] Ang = (64'(g) * HALF_PI_Q30 + 64'(SINE_TABLE_SIZE / 2))
                                      / 64'(SINE_TABLE_SIZE);
        localparam logic [63:0] Sq  = (Ang * Ang) >> 30;
        localparam logic [63:0] M1  = ((Ang * Sq) >> 30) / 64'd6;
        localparam logic [63:0] M2  = ((M1 * Sq) >> 30) / 64'd20;
        localparam logic [63:0] M3  = ((M2 * Sq) >> 30) / 64'd42;
        localparam logic [63:0] M4  = ((M3 * Sq) >> 30) / 64'd72;
        localparam logic [63:0] M5  = ((M4 * Sq) >> 30) / 64'd110;
        localparam logic [63:0] M6  = ((M5 * Sq) >> 30) / 64'd156;
        localparam logic [63:0] Sum = Ang - M1 + M2 - M3 + M4 - M5 + M6;
        localparam logic [63:0] Rnd = (Sum + 64'd8192) >> 14;
        localparam logic [63:0] Ent = (Rnd > 64'(MIX_ONE)) ? 64'(MIX_ONE) : Rnd;
        assign rom_q[g] = MIX_BITS'(Ent);
    end

    // registered reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            sin_gain_reg <= rom_q[sin_idx];
            cos_gain_reg <= rom_q[cos_idx];
        end
    end

    assign sin_gain = sin_gain_reg;
    assign cos_gain = cos_gain_reg;

endmodule

// ===== hw/rtl/sepx_mod_div.sv =====
// restoring modulo unit: 48-bit dividend by 17-bit divisor, one bit per cycle
// depends on sepx_pkg

module sepx_mod_div (
    input  logic                clk,
    input  logic                rst_n,
    input  sepx_pkg::div_req_t  req,
    output sepx_pkg::div_resp_t resp
);
    import sepx_pkg::*;

    localparam int CW = $clog2(HOST_BITS);
    localparam logic [CW-1:0] CntLast = CW'(HOST_BITS - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [HOST_BITS-1:0] quo_reg, quo_next;
    logic [LEN_BITS-1:0]  rem_reg, rem_next;
    logic [LEN_BITS-1:0]  div_reg, div_next;
    logic [LEN_BITS:0]    trial;

    // one shift-subtract step per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        trial     = {rem_reg, quo_reg[HOST_BITS-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[HOST_BITS-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = LEN_BITS'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[LEN_BITS-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CntLast)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign resp.busy      = busy_reg;
    assign resp.done      = done_reg;
    assign resp.remainder = rem_reg;

endmodule

// ===== hw/rtl/sepx_lane.sv =====
// one channel lane: comparison sample store, gain products, round and saturate
// depends on sepx_pkg

module sepx_lane #(
    parameter int SAMPLE_BITS = sepx_pkg::SAMPLE_BITS_DEF,
    parameter int AW          = $clog2(sepx_pkg::STORE_DEPTH)
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic signed [SAMPLE_BITS-1:0] wr_data,
    input  logic [AW-1:0]                 rd_addr,
    input  sepx_pkg::lane_ctrl_t          ctrl,
    input  logic signed [SAMPLE_BITS-1:0] live,
    input  logic [sepx_pkg::MIX_BITS-1:0] cos_gain,
    input  logic [sepx_pkg::MIX_BITS-1:0] sin_gain,
    output logic signed [SAMPLE_BITS-1:0] mixed
);
    import sepx_pkg::*;

    localparam int PW = SAMPLE_BITS + MIX_BITS + 1;
    localparam int SW = PW + 1;
    localparam logic signed [SW-1:0] RoundHalf = SW'(32768);
    localparam logic signed [SW-1:0] SatHi =
        SW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SatLo = ~SatHi;

    logic signed [SAMPLE_BITS-1:0] store_mem [STORE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] snap_reg;
    logic                          snap_ok_reg;
    logic signed [SAMPLE_BITS-1:0] snap_sel;
    logic signed [PW-1:0]          p_live_reg;
    logic signed [PW-1:0]          p_snap_reg;
    logic signed [SW-1:0]          sum_w;
    logic signed [SW-1:0]          shifted;

    // store write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    // store read at the playhead
    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            snap_reg    <= store_mem[rd_addr];
            snap_ok_reg <= ctrl.snap_ok;
        end
    end

    // zero past the channel length
    always_comb
    begin
        snap_sel = snap_ok_reg ? snap_reg : '0;
    end

    // gain products
    always_ff @(posedge clk)
    begin
        if (ctrl.prod_en)
        begin
            p_live_reg <= live * $signed({1'b0, cos_gain});
            p_snap_reg <= snap_sel * $signed({1'b0, sin_gain});
        end
    end

    // sum, round half up, saturate
    always_comb
    begin
        sum_w   = SW'(p_live_reg) + SW'(p_snap_reg) + RoundHalf;
        shifted = sum_w >>> 16;
        if (shifted > SatHi)
        begin
            mixed = SAMPLE_BITS'(SatHi);
        end
        else if (shifted < SatLo)
        begin
            mixed = SAMPLE_BITS'(SatLo);
        end
        else
        begin
            mixed = SAMPLE_BITS'(shifted);
        end
    end

endmodule

// ===== hw/rtl/smoothed_equal_power_ab_crossfader.sv =====
// smoothed equal-power a/b crossfader, top level: config, sequencer, lanes, merge
// a frame runs through fetch, product and sum; a block-start resync runs modulo first
// a new frame is taken only when idle, load requests one per cycle while idle; the
// 48-step modulo unit sets the extra cost of resync and of wrap after a length change
// reset: registers to defaults, mix and playhead zero; stores are not cleared
// depends on sepx_pkg, sepx_in_if, sepx_out_if, sepx_gain_rom, sepx_mod_div, sepx_lane

module smoothed_equal_power_ab_crossfader #(
    parameter int SINE_TABLE_SIZE = sepx_pkg::SINE_TABLE_SIZE_DEF,
    parameter int SAMPLE_BITS     = sepx_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [sepx_pkg::CFG_INDEX_BITS-1:0] wr_index,
    input  logic [sepx_pkg::CFG_DATA_BITS-1:0]  wr_data,
    sepx_in_if.sink                             frame,
    sepx_out_if.source                          mixed
);
    import sepx_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int IW = $clog2(SINE_TABLE_SIZE + 1);
    localparam logic [IW-1:0] IdxMax = IW'(SINE_TABLE_SIZE);

    // registers
    state_t                        state_reg, state_next;
    logic [MIX_BITS-1:0]           target_mix_reg;
    logic [CH_BITS-1:0]            channel_count_reg;
    logic [LEN_BITS-1:0]           left_length_reg;
    logic [LEN_BITS-1:0]           right_length_reg;
    logic [MIX_BITS-1:0]           current_mix_reg, current_mix_next;
    logic [PH_BITS-1:0]            playhead_reg, playhead_next;
    logic                          playing_reg;
    logic signed [SAMPLE_BITS-1:0] live_left_reg;
    logic signed [SAMPLE_BITS-1:0] live_right_reg;
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_left_reg;
    logic signed [SAMPLE_BITS-1:0] out_right_reg;

    // combinational signals
    logic                          accept;
    logic                          process_go;
    logic                          resync;
    logic                          sum_fire;
    logic                          adv_en;
    logic                          wrap_slow;
    logic                          load_hit;
    logic [LEN_BITS-1:0]           llen;
    logic [LEN_BITS-1:0]           rlen;
    logic [LEN_BITS-1:0]           tgt;
    logic [LEN_BITS-1:0]           ph_inc;
    logic [LEN_BITS-1:0]           ph_sub;
    logic                          tgt_ge;
    logic [MIX_BITS-1:0]           diff;
    logic [31:0]                   step_prod;
    logic [MIX_BITS-1:0]           step;
    logic [31:0]                   idx_prod;
    logic [15:0]                   idx_raw;
    logic [IW-1:0]                 sin_idx;
    logic [IW-1:0]                 cos_idx;
    logic [MIX_BITS-1:0]           sin_gain;
    logic [MIX_BITS-1:0]           cos_gain;
    logic signed [SAMPLE_BITS-1:0] left_mixed;
    logic signed [SAMPLE_BITS-1:0] right_mixed;
    lane_ctrl_t                    left_ctrl;
    lane_ctrl_t                    right_ctrl;
    div_req_t                      div_req;
    div_resp_t                     div_resp;

    // request decode and clamps
    always_comb
    begin
        accept     = frame.valid && frame.ready;
        process_go = accept && (frame.mode == MODE_PROCESS) && (channel_count_reg != '0);
        load_hit   = 32'(frame.load_index) < 32'(STORE_DEPTH);
        llen = (32'(left_length_reg) > 32'(STORE_DEPTH)) ?
               LEN_BITS'(STORE_DEPTH) : left_length_reg;
        rlen = (32'(right_length_reg) > 32'(STORE_DEPTH)) ?
               LEN_BITS'(STORE_DEPTH) : right_length_reg;
        resync    = frame.block_start && frame.is_playing && (llen != '0);
        sum_fire  = (state_reg == ST_SUM) && (!out_valid_reg || mixed.ready);
        adv_en    = playing_reg && (llen != '0);
        ph_inc    = {1'b0, playhead_reg} + 1'b1;
        ph_sub    = ph_inc - llen;
        wrap_slow = adv_en && (ph_inc >= llen) && (ph_sub >= llen);
    end

    // one-pole smoothing step toward the target
    always_comb
    begin
        tgt       = (target_mix_reg > MIX_ONE) ? MIX_ONE : target_mix_reg;
        tgt_ge    = tgt >= current_mix_reg;
        diff      = tgt_ge ? (tgt - current_mix_reg) : (current_mix_reg - tgt);
        step_prod = 32'(diff) * 32'(SMOOTH_Q16) + 32'd32768;
        step      = MIX_BITS'(step_prod >> 16);
        if (step == '0 && diff != '0)
        begin
            step = MIX_BITS'(1);
        end
    end

    // gain table index
    always_comb
    begin
        idx_prod = 32'(current_mix_reg) * 32'(SINE_TABLE_SIZE) + 32'd32768;
        idx_raw  = idx_prod[31:16];
        sin_idx  = (32'(idx_raw) > 32'(SINE_TABLE_SIZE)) ? IdxMax : IW'(idx_raw);
        cos_idx  = IdxMax - sin_idx;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (process_go)
                begin
                    state_next = resync ? ST_MOD : ST_FETCH;
                end
            end
            ST_MOD:
            begin
                if (div_resp.done)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: state_next = ST_PROD;
            ST_PROD:  state_next = ST_SUM;
            ST_SUM:
            begin
                if (sum_fire)
                begin
                    state_next = wrap_slow ? ST_WRAP : ST_IDLE;
                end
            end
            ST_WRAP:
            begin
                if (div_resp.done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath next values
    always_comb
    begin
        frame.ready = (state_reg == ST_IDLE);

        div_req.start    = (process_go && resync) || (sum_fire && wrap_slow);
        div_req.dividend = (state_reg == ST_IDLE) ? frame.host_position : HOST_BITS'(ph_inc);
        div_req.divisor  = llen;

        left_ctrl.rd_en    = (state_reg == ST_FETCH);
        left_ctrl.snap_ok  = {1'b0, playhead_reg} < llen;
        left_ctrl.prod_en  = (state_reg == ST_PROD);
        right_ctrl.rd_en   = (state_reg == ST_FETCH);
        right_ctrl.snap_ok = {1'b0, playhead_reg} < rlen;
        right_ctrl.prod_en = (state_reg == ST_PROD);

        current_mix_next = current_mix_reg;
        if (process_go)
        begin
            current_mix_next = tgt_ge ? (current_mix_reg + step) : (current_mix_reg - step);
        end

        playhead_next = playhead_reg;
        if (accept && (frame.mode == MODE_LOAD) && (frame.load_index == '0))
        begin
            playhead_next = '0;
        end
        else if (((state_reg == ST_MOD) || (state_reg == ST_WRAP)) && div_resp.done)
        begin
            playhead_next = PH_BITS'(div_resp.remainder);
        end
        else if (sum_fire && adv_en && !wrap_slow)
        begin
            playhead_next = (ph_inc < llen) ? PH_BITS'(ph_inc) : PH_BITS'(ph_sub);
        end

        out_valid_next = out_valid_reg;
        if (mixed.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (sum_fire)
        begin
            out_valid_next = 1'b1;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_mix_reg    <= '0;
            channel_count_reg <= CH_BITS'(2);
            left_length_reg   <= '0;
            right_length_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (cfg_reg_t'(wr_index))
                REG_TARGET_MIX:    target_mix_reg    <= wr_data;
                REG_CHANNEL_COUNT: channel_count_reg <= wr_data[CH_BITS-1:0];
                REG_LEFT_LENGTH:   left_length_reg   <= wr_data;
                REG_RIGHT_LENGTH:  right_length_reg  <= wr_data;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            current_mix_reg <= '0;
            playhead_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            current_mix_reg <= current_mix_next;
            playhead_reg    <= playhead_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // frame capture and merged result register
    always_ff @(posedge clk)
    begin
        if (process_go)
        begin
            live_left_reg  <= frame.left_sample;
            live_right_reg <= frame.right_sample;
            playing_reg    <= frame.is_playing;
        end
        if (sum_fire)
        begin
            out_left_reg  <= left_mixed;
            out_right_reg <= channel_count_reg[1] ? right_mixed : '0;
        end
    end

    assign mixed.valid     = out_valid_reg;
    assign mixed.out_left  = out_left_reg;
    assign mixed.out_right = out_right_reg;

    // gain rom
    sepx_gain_rom #(
        .SINE_TABLE_SIZE(SINE_TABLE_SIZE)
    ) u_gain_rom (
        .clk     (clk),
        .rd_en   (state_reg == ST_FETCH),
        .sin_idx (sin_idx),
        .cos_idx (cos_idx),
        .sin_gain(sin_gain),
        .cos_gain(cos_gain)
    );

    // modulo unit for resync and wrap
    sepx_mod_div u_mod_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .resp (div_resp)
    );

    // left and right lanes
    sepx_lane #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane_left (
        .clk     (clk),
        .wr_en   (accept && (frame.mode == MODE_LOAD) && load_hit),
        .wr_addr (AW'(frame.load_index)),
        .wr_data (frame.left_sample),
        .rd_addr (AW'(playhead_reg)),
        .ctrl    (left_ctrl),
        .live    (live_left_reg),
        .cos_gain(cos_gain),
        .sin_gain(sin_gain),
        .mixed   (left_mixed)
    );

    sepx_lane #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane_right (
        .clk     (clk),
        .wr_en   (accept && (frame.mode == MODE_LOAD) && load_hit),
        .wr_addr (AW'(frame.load_index)),
        .wr_data (frame.right_sample),
        .rd_addr (AW'(playhead_reg)),
        .ctrl    (right_ctrl),
        .live    (live_right_reg),
        .cos_gain(cos_gain),
        .sin_gain(sin_gain),
        .mixed   (right_mixed)
    );

`ifndef ASSERT_OFF
    // smoothing never overshoots full comparison
    a_mix_range: assert property (@(posedge clk) disable iff (!rst_n)
        current_mix_reg <= MIX_ONE)
        else $error("current mix above one");

    // a load request never produces a result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (frame.mode == MODE_LOAD)) |=> !$rose(out_valid_reg))
        else $error("result after load request");

    // modulo unit is only started when free
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_resp.busy)
        else $error("modulo unit restarted while busy");

    // loading index zero rewinds the playhead
    a_rewind: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (frame.mode == MODE_LOAD) && (frame.load_index == '0))
        |=> (playhead_reg == '0))
        else $error("playhead not rewound");
`endif

endmodule

// ===== test/tb.sv =====
// testbench of the smoothed equal-power crossfader: directed table, store fill, then random phases
// depends on sepx_pkg, sepx_in_if, sepx_out_if and smoothed_equal_power_ab_crossfader

module tb;
    import sepx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SB       = SAMPLE_BITS_DEF;
    localparam int TBL      = SINE_TABLE_SIZE_DEF;
    localparam int DEPTH    = STORE_DEPTH;
    localparam int SETTLE   = 80;
    localparam int HOLD_LEN = 300;
    localparam int FILL_LEN = 64;

    typedef logic signed [SB-1:0] smp_t;

    typedef struct packed {
        mode_t                mode;
        smp_t                 left;
        smp_t                 right;
        logic [INDEX_BITS-1:0] index;
        logic                 bstart;
        logic                 play;
        logic [HOST_BITS-1:0] host;
    } req_t;

    typedef struct packed {
        smp_t l;
        smp_t r;
    } frame_t;

    // directed row: typed expectation only where obvious
    typedef struct packed {
        req_t   req;
        logic   typed;
        frame_t want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] wr_index = '0;
    logic [CFG_DATA_BITS-1:0] wr_data = '0;

    sepx_in_if  #(.SAMPLE_BITS(SB)) frame ();
    sepx_out_if #(.SAMPLE_BITS(SB)) mixed ();

    smoothed_equal_power_ab_crossfader u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .frame    (frame),
        .mixed    (mixed)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state
    longint unsigned gain_lut [0:TBL];
    int unsigned     tgt_reg, chan_reg, llen_reg, rlen_reg;
    int unsigned     mix_now, play_pos;
    smp_t            left_mem [0:DEPTH-1];
    smp_t            right_mem [0:DEPTH-1];
    bit              left_seen [0:DEPTH-1];
    bit              right_seen [0:DEPTH-1];
    frame_t          pending_frames [$];
    // per result: left and right are checkable (no never-written store entry read)
    bit [1:0]        pending_known [$];

    int errors = 0;
    int accepted = 0;
    int snd_idle = 9;
    int rcv_idle = 59;
    bit pressure_req = 0;

    // quarter-wave gain table, taylor series in q2.30
    function automatic void build_gains();
        longint unsigned t, t2, sum, term, v;
        for (int i = 0; i <= TBL; i++)
        begin
            t = (longint'(i) * HALF_PI_Q30 + TBL / 2) / TBL;
            t2 = (t * t) >> 30;
            sum = t;
            term = t;
            for (int k = 1; k <= 6; k++)
            begin
                term = (term * t2) >> 30;
                term = term / ((2 * k) * (2 * k + 1));
                if (k % 2 == 1) sum = sum - term;
                else sum = sum + term;
            end
            v = (sum + 8192) >> 14;
            gain_lut[i] = (v > 65536) ? 65536 : v;
        end
    endfunction

    function automatic smp_t blend(smp_t live, smp_t snap, longint cg, longint sg);
        longint acc;
        longint hi;
        hi = (longint'(1) <<< (SB - 1)) - 1;
        acc = (longint'(live) * cg + longint'(snap) * sg + 32768) >>> 16;
        if (acc > hi) acc = hi;
        if (acc < -hi - 1) acc = -hi - 1;
        return smp_t'(acc);
    endfunction

    // advance the crossfader model by one accepted request
    function automatic void predict_mix(req_t q);
        int unsigned ll, rl, goal, diff, stp, idx;
        longint cg, sg;
        smp_t snl, snr;
        frame_t f;
        bit [1:0] kn;
        if (q.mode == MODE_LOAD)
        begin
            left_mem[q.index] = q.left;
            right_mem[q.index] = q.right;
            left_seen[q.index] = 1'b1;
            right_seen[q.index] = 1'b1;
            if (q.index == 0) play_pos = 0;
            return;
        end
        if (chan_reg == 0) return;
        ll = (llen_reg > DEPTH) ? DEPTH : llen_reg;
        rl = (rlen_reg > DEPTH) ? DEPTH : rlen_reg;
        if (q.bstart && q.play && ll != 0) play_pos = 32'(q.host % ll);
        goal = (tgt_reg > 65536) ? 65536 : tgt_reg;
        diff = (goal >= mix_now) ? goal - mix_now : mix_now - goal;
        stp = 32'((longint'(diff) * SMOOTH_Q16 + 32768) >> 16);
        // smoothing never stalls short of the target
        if (stp == 0 && diff != 0) stp = 1;
        if (goal >= mix_now) mix_now = mix_now + stp;
        else mix_now = mix_now - stp;
        idx = 32'((longint'(mix_now) * TBL + 32768) >> 16);
        if (idx > TBL) idx = TBL;
        sg = gain_lut[idx];
        cg = gain_lut[TBL - idx];
        snl = (play_pos < ll) ? left_mem[play_pos] : '0;
        snr = (play_pos < rl) ? right_mem[play_pos] : '0;
        kn[1] = (play_pos >= ll) || left_seen[play_pos];
        kn[0] = (chan_reg < 2) || (play_pos >= rl) || right_seen[play_pos];
        f.l = blend(q.left, snl, cg, sg);
        f.r = (chan_reg >= 2) ? blend(q.right, snr, cg, sg) : '0;
        pending_frames.push_back(f);
        pending_known.push_back(kn);
        if (q.play && ll != 0) play_pos = (play_pos + 1) % ll;
    endfunction

    // idle-state register write
    task automatic write_reg(cfg_reg_t r, int unsigned val);
        while (pending_frames.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= r;
        wr_data <= val[CFG_DATA_BITS-1:0];
        @(posedge clk);
        wr_en <= 1'b0;
        case (r)
            REG_TARGET_MIX:    tgt_reg = val & 32'h1FFFF;
            REG_CHANNEL_COUNT: chan_reg = val & 32'h3;
            REG_LEFT_LENGTH:   llen_reg = val & 32'h1FFFF;
            default:           rlen_reg = val & 32'h1FFFF;
        endcase
    endtask

    // offer one request and wait until it is taken
    task automatic send_req(req_t q, output logic done);
        while ($urandom_range(99) < snd_idle)
        begin
            frame.valid <= 1'b0;
            @(posedge clk);
        end
        frame.valid <= 1'b1;
        frame.mode <= q.mode;
        frame.left_sample <= q.left;
        frame.right_sample <= q.right;
        frame.load_index <= q.index;
        frame.block_start <= q.bstart;
        frame.is_playing <= q.play;
        frame.host_position <= q.host;
        do @(posedge clk); while (!frame.ready);
        predict_mix(q);
        accepted++;
        done = 1'b1;
    endtask

    function automatic smp_t rand_sample();
        case ($urandom_range(7))
            0: return smp_t'(24'h7FFFFF);
            1: return smp_t'(24'h800000);
            2: return smp_t'($urandom_range(3)) - smp_t'(1);
            default: return smp_t'($urandom);
        endcase
    endfunction

    function automatic req_t rand_req(int unsigned span);
        req_t q;
        q.mode = ($urandom_range(99) < 18) ? MODE_LOAD : MODE_PROCESS;
        q.left = rand_sample();
        q.right = rand_sample();
        q.index = ($urandom_range(9) == 0) ? INDEX_BITS'($urandom) :
                  INDEX_BITS'($urandom_range(span));
        q.bstart = ($urandom_range(9) == 0);
        q.play = ($urandom_range(9) < 7);
        q.host = {$urandom, $urandom};
        return q;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && mixed.valid && mixed.ready)
        begin
            if (pending_frames.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected frame %0d %0d",
                                           mixed.out_left, mixed.out_right);
            end
            else
            begin
                frame_t w;
                bit [1:0] kn;
                w = pending_frames.pop_front();
                kn = pending_known.pop_front();
                if ((kn[1] && w.l !== mixed.out_left) ||
                    (kn[0] && w.r !== mixed.out_right))
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: want %0d %0d got %0d %0d",
                                 w.l, w.r, mixed.out_left, mixed.out_right);
                end
            end
        end
    end

    // output back-pressure with a long hold when asked
    int hold_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mixed.ready <= 1'b0;
        end
        else
        begin
            if (pressure_req)
            begin
                pressure_req = 0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                mixed.ready <= 1'b0;
            end
            else
            begin
                mixed.ready <= ($urandom_range(99) >= rcv_idle);
            end
        end
    end

    // watchdog
    initial
    begin
        #10ms;
        $display("DONE: errors detected");
        $finish;
    end

    // stimulus
    initial
    begin
        row_t rows [$];
        row_t rw;
        req_t q;
        logic ok;
        int unsigned phase_cfg [8][4] = '{
            '{65536, 2, 16, 8}, '{131071, 1, 40, 40}, '{0, 3, 0, 5},
            '{30000, 0, 10, 10}, '{65535, 2, 131071, 65536}, '{1, 2, 65536, 0},
            '{40000, 2, 7, 100}, '{20000, 1, 3, 131071}
        };

        frame.valid = 1'b0;
        frame.mode = MODE_LOAD;
        frame.left_sample = '0;
        frame.right_sample = '0;
        frame.load_index = '0;
        frame.block_start = 1'b0;
        frame.is_playing = 1'b0;
        frame.host_position = '0;
        build_gains();
        tgt_reg = 0;
        chan_reg = 2;
        llen_reg = 0;
        rlen_reg = 0;
        mix_now = 0;
        play_pos = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows: with mix at zero the live samples pass through
        rw = '0;
        rw.req.mode = MODE_PROCESS;
        rw.typed = 1'b1;
        rw.req.left = smp_t'(24'h7FFFFF); rw.req.right = smp_t'(24'h800000);
        rw.want.l = smp_t'(24'h7FFFFF); rw.want.r = smp_t'(24'h800000);
        rows.push_back(rw);
        rw.req.left = smp_t'(24'h800000); rw.req.right = smp_t'(24'h7FFFFF);
        rw.want.l = smp_t'(24'h800000); rw.want.r = smp_t'(24'h7FFFFF);
        rw.req.play = 1'b1; rw.req.bstart = 1'b1; rw.req.host = '1;
        rows.push_back(rw);
        rw.req.left = '0; rw.req.right = -smp_t'(1);
        rw.want.l = '0; rw.want.r = -smp_t'(1);
        rw.req.play = 1'b0; rw.req.bstart = 1'b1; rw.req.host = '0;
        rows.push_back(rw);
        rw = '0;
        rw.req.mode = MODE_LOAD;
        rw.req.index = '1; rw.req.left = smp_t'(24'h7FFFFF);
        rw.req.right = smp_t'(24'h800000);
        rows.push_back(rw);
        rw.req.index = '0; rw.req.left = smp_t'(24'h800000); rw.req.right = smp_t'(1);
        rows.push_back(rw);
        for (int i = 0; i < 12; i++)
        begin
            rw = '0;
            rw.req = rand_req(DEPTH - 1);
            rows.push_back(rw);
        end
        foreach (rows[i])
        begin
            send_req(rows[i].req, ok);
            if (rows[i].typed)
            begin
                frame_t p;
                p = pending_frames[pending_frames.size() - 1];
                if (p != rows[i].want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("directed row %0d: want %0d %0d got %0d %0d", i,
                                 rows[i].want.l, rows[i].want.r, p.l, p.r);
                end
            end
        end

        // fill the low store entries that short lengths and random loads use
        for (int i = 0; i < FILL_LEN; i++)
        begin
            q = '0;
            q.mode = MODE_LOAD;
            q.index = INDEX_BITS'(i);
            q.left = rand_sample();
            q.right = rand_sample();
            send_req(q, ok);
        end
        frame.valid <= 1'b0;

        // random phases under several register settings
        accepted = 0;
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(REG_TARGET_MIX, phase_cfg[ph][0]);
            write_reg(REG_CHANNEL_COUNT, phase_cfg[ph][1]);
            write_reg(REG_LEFT_LENGTH, phase_cfg[ph][2]);
            write_reg(REG_RIGHT_LENGTH, phase_cfg[ph][3]);
            if (ph == 1) pressure_req = 1;
            for (int n = 0; n < 86; n++)
            begin
                if (accepted < 256)
                begin
                    snd_idle = 9;
                    rcv_idle = 59;
                end
                else if (accepted < 512)
                begin
                    snd_idle = 59;
                    rcv_idle = 9;
                end
                else
                begin
                    snd_idle = 0;
                    rcv_idle = 0;
                end
                q = rand_req(($urandom_range(3) == 0) ? DEPTH - 1 : FILL_LEN - 1);
                send_req(q, ok);
            end
            frame.valid <= 1'b0;
            // a target change mid-phase keeps the smoother moving
            write_reg(REG_TARGET_MIX, $urandom_range(65536));
            for (int n = 0; n < 10; n++)
            begin
                q = rand_req(FILL_LEN - 1);
                send_req(q, ok);
            end
            frame.valid <= 1'b0;
        end

        // drain
        while (pending_frames.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0 && pending_frames.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
